// ===== sv/rcs_pkg.sv =====
// ---------------------------------------------------------------------------
// rcs_pkg
// shared types and codes of the rgb contrast stretch block
// ---------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

  localparam int unsigned NUM_CHAN = 3;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_STRETCH = 1'b1;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_MAX,
    RES_DIV
  } res_kind_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

// ===== sv/rcs_in_if.sv =====
// ---------------------------------------------------------------------------
// rcs_in_if
// pixel input channel: valid/ready handshake with opcode and rgb payload
// ---------------------------------------------------------------------------
`default_nettype none

interface rcs_in_if #(
  parameter int W = 8
) ();
  logic         valid;
  logic         ready;
  logic         opcode;
  logic         start_frame;
  logic [W-1:0] red_in;
  logic [W-1:0] green_in;
  logic [W-1:0] blue_in;

  modport source (
    output valid, opcode, start_frame, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, opcode, start_frame, red_in, green_in, blue_in,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/rcs_out_if.sv =====
// ---------------------------------------------------------------------------
// rcs_out_if
// stretched pixel output channel: valid/ready handshake with rgb payload
// ---------------------------------------------------------------------------
`default_nettype none

interface rcs_out_if #(
  parameter int W = 8
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] red_out;
  logic [W-1:0] green_out;
  logic [W-1:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/rgb_contrast_stretch.sv =====
// ---------------------------------------------------------------------------
// rgb_contrast_stretch
// per-channel min/max contrast stretch, measure pass and stretch pass
// ---------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   in_beat   in   valid/ready    opcode, start_frame, red_in, green_in, blue_in
//   out_beat  out  valid/ready    red_out, green_out, blue_out
//
// a measure beat leaves the block ready; measure beats can follow back to back
// a stretch beat keeps the block busy until its result moves on: the three
//   restoring dividers produce one quotient bit per cycle each
// reset clears the bounds at once (low to all ones, high to zero)
// a result not yet taken holds the block in its finish cycle; once it moves to
//   the output register the next beat is taken while that result still waits
// ---------------------------------------------------------------------------
`default_nettype none

module rgb_contrast_stretch
  import rcs_pkg::*;
#(
  parameter int COMPONENT_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rcs_in_if.sink    in_beat,
  rcs_out_if.source out_beat
);

  localparam int N  = COMPONENT_BITS;
  localparam int CW = $clog2(COMPONENT_BITS);
  localparam logic [N-1:0]  MAXV     = '1;
  localparam logic [CW-1:0] CNT_LAST = CW'(COMPONENT_BITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [N-1:0]  lo_r    [NUM_CHAN];
  logic [N-1:0]  hi_r    [NUM_CHAN];
  logic [N-1:0]  lo_nxt  [NUM_CHAN];
  logic [N-1:0]  hi_nxt  [NUM_CHAN];
  logic [N-1:0]  pix     [NUM_CHAN];
  res_kind_t     kind_r  [NUM_CHAN];
  res_kind_t     kind_ld [NUM_CHAN];
  logic [N-1:0]  num_hi  [NUM_CHAN];
  logic [N-1:0]  num_lo  [NUM_CHAN];
  logic [N-1:0]  dvsr    [NUM_CHAN];
  logic [N-1:0]  quot    [NUM_CHAN];
  logic [N-1:0]  res     [NUM_CHAN];
  logic [N-1:0]  res_r   [NUM_CHAN];

  div_ctl_t      div_ctl;
  logic          in_acc;
  logic          measure_acc;
  logic          stretch_acc;
  logic          out_free;

  assign pix[0] = in_beat.red_in;
  assign pix[1] = in_beat.green_in;
  assign pix[2] = in_beat.blue_in;

  assign in_beat.ready = (state_r == S_IDLE);
  assign in_acc        = in_beat.valid && in_beat.ready;
  assign measure_acc   = in_acc && (in_beat.opcode == OP_MEASURE);
  assign stretch_acc   = in_acc && (in_beat.opcode == OP_STRETCH);
  assign out_free      = !out_valid_r || out_beat.ready;

  assign div_ctl.load = stretch_acc;
  assign div_ctl.step = (state_r == S_RUN);

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    logic [N-1:0]   lo_base;
    logic [N-1:0]   hi_base;
    logic [N-1:0]   diff;
    logic [2*N-1:0] num;

    // bounds update for a measure beat
    assign lo_base   = in_beat.start_frame ? MAXV : lo_r[c];
    assign hi_base   = in_beat.start_frame ? '0 : hi_r[c];
    assign lo_nxt[c] = measure_acc ? ((pix[c] < lo_base) ? pix[c] : lo_base) : lo_r[c];
    assign hi_nxt[c] = measure_acc ? ((pix[c] > hi_base) ? pix[c] : hi_base) : hi_r[c];

    // (v - low) * MAXV as a shift and subtract
    assign diff      = pix[c] - lo_r[c];
    assign num       = {diff, {N{1'b0}}} - {{N{1'b0}}, diff};
    assign num_hi[c] = num[2*N-1:N];
    assign num_lo[c] = num[N-1:0];
    assign dvsr[c]   = hi_r[c] - lo_r[c];

    always_comb begin
      if (hi_r[c] <= lo_r[c]) begin
        kind_ld[c] = RES_ZERO;
      end else if (pix[c] <= lo_r[c]) begin
        kind_ld[c] = RES_ZERO;
      end else if (pix[c] >= hi_r[c]) begin
        kind_ld[c] = RES_MAX;
      end else begin
        kind_ld[c] = RES_DIV;
      end
    end

    always_comb begin
      case (kind_r[c])
        RES_DIV: res[c] = quot[c];
        RES_MAX: res[c] = MAXV;
        default: res[c] = '0;
      endcase
    end

    rcs_div #(
      .W (N)
    ) u_div (
      .clk      (clk),
      .ctl      (div_ctl),
      .num_hi   (num_hi[c]),
      .num_lo   (num_lo[c]),
      .divisor  (dvsr[c]),
      .quotient (quot[c])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lo_r[c] <= MAXV;
        hi_r[c] <= '0;
      end else begin
        lo_r[c] <= lo_nxt[c];
        hi_r[c] <= hi_nxt[c];
      end
      if (stretch_acc) begin
        kind_r[c] <= kind_ld[c];
      end
      if ((state_r == S_DONE) && out_free) begin
        res_r[c] <= res[c];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_beat.ready;
    unique case (state_r)
      S_IDLE: begin
        if (stretch_acc) begin
          state_nxt = S_RUN;
          cnt_nxt   = CNT_LAST;
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_beat.valid     = out_valid_r;
  assign out_beat.red_out   = res_r[0];
  assign out_beat.green_out = res_r[1];
  assign out_beat.blue_out  = res_r[2];

`ifndef SYNTHESIS
  a_stretch_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    stretch_acc |=> (state_r == S_RUN) && (cnt_r == CNT_LAST))
    else $error("stretch beat did not start the divider run");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    measure_acc |=> (lo_r[0] <= hi_r[0]) && (lo_r[1] <= hi_r[1]) && (lo_r[2] <= hi_r[2]))
    else $error("bounds out of order after a measure beat");

  a_bounds_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(lo_r[0]) && $stable(hi_r[0]) && $stable(lo_r[1])
      && $stable(hi_r[1]) && $stable(lo_r[2]) && $stable(hi_r[2]))
    else $error("bounds changed during a stretch");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_beat.ready)) |-> ($past(state_r) == S_DONE))
    else $error("result appeared without a finished division");
`endif

endmodule

`default_nettype wire

// ===== sv/rcs_div.sv =====
// ---------------------------------------------------------------------------
// rcs_div
// restoring divider, one quotient bit per step; quotient must fit in W bits
// ---------------------------------------------------------------------------
`default_nettype none

module rcs_div
  import rcs_pkg::*;
#(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire div_ctl_t     ctl,
  input  wire logic [W-1:0] num_hi,
  input  wire logic [W-1:0] num_lo,
  input  wire logic [W-1:0] divisor,
  output logic      [W-1:0] quotient
);

  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] low_r, low_nxt;
  logic [W-1:0] div_r;
  logic [W:0]   trial;
  logic [W:0]   trial_sub;
  logic         fits;

  assign trial     = {rem_r, low_r[W-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign fits      = (trial >= {1'b0, div_r});

  always_comb begin
    rem_nxt = rem_r;
    low_nxt = low_r;
    if (ctl.load) begin
      rem_nxt = num_hi;
      low_nxt = num_lo;
    end else if (ctl.step) begin
      rem_nxt = fits ? trial_sub[W-1:0] : trial[W-1:0];
      low_nxt = {low_r[W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    if (ctl.load) begin
      div_r <= divisor;
    end
  end

  assign quotient = low_r;

endmodule

`default_nettype wire

// ===== test/rcs_stretch_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcs_stretch_checker
// watches the pixel and result channels of the contrast stretch block, keeps
// its own running channel bounds, predicts every stretched pixel and compares
// each result beat field by field with the oldest prediction
// ---------------------------------------------------------------------------

module rcs_stretch_checker
  import rcs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rcs_in_if    in_mon,
  rcs_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct {
    logic [7:0] low;
    logic [7:0] high;
  } bounds_t;

  bounds_t bounds [NUM_CHAN];
  rgb_t    stretched_q [$];
  int      mismatches;

  function automatic logic [7:0] stretch_component(logic [7:0] v, logic [7:0] lo,
                                                   logic [7:0] hi);
    int unsigned offset;
    int unsigned span;
    if (hi <= lo) return 8'd0;
    if (v <= lo) return 8'd0;
    if (v >= hi) return 8'hFF;
    offset = int'(v) - int'(lo);
    span   = int'(hi) - int'(lo);
    return 8'((offset * 255) / span);
  endfunction

  task automatic clear_bounds();
    for (int c = 0; c < NUM_CHAN; c++) begin
      bounds[c].low  = 8'hFF;
      bounds[c].high = 8'h00;
    end
  endtask

  task automatic widen_bounds(int c, logic [7:0] v);
    if (v < bounds[c].low) bounds[c].low = v;
    if (v > bounds[c].high) bounds[c].high = v;
  endtask

  task automatic compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rgb_t exp_pix;
    rgb_t new_pix;
    if (!rst_n) begin
      clear_bounds();
      stretched_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (stretched_q.size() == 0) begin
          $error("result beat with no pixel expected: %0d %0d %0d",
                 out_mon.red_out, out_mon.green_out, out_mon.blue_out);
          mismatches++;
        end else begin
          exp_pix = stretched_q.pop_front();
          compare_field("red_out", exp_pix.red, out_mon.red_out);
          compare_field("green_out", exp_pix.green, out_mon.green_out);
          compare_field("blue_out", exp_pix.blue, out_mon.blue_out);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == OP_MEASURE) begin
          if (in_mon.start_frame) clear_bounds();
          widen_bounds(0, in_mon.red_in);
          widen_bounds(1, in_mon.green_in);
          widen_bounds(2, in_mon.blue_in);
        end else begin
          new_pix.red   = stretch_component(in_mon.red_in, bounds[0].low, bounds[0].high);
          new_pix.green = stretch_component(in_mon.green_in, bounds[1].low,
                                            bounds[1].high);
          new_pix.blue  = stretch_component(in_mon.blue_in, bounds[2].low, bounds[2].high);
          stretched_q.push_back(new_pix);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= stretched_q.size();
  end

endmodule

// ===== test/rgb_contrast_stretch_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_contrast_stretch_tb
// drives measure and stretch frames into the contrast stretch block under
// random sender and receiver idling, with a side checker predicting results
// ---------------------------------------------------------------------------

module rgb_contrast_stretch_tb
  import rcs_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 600;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   items_sent;
  int   stall_cycles;

  rcs_in_if  #(.W(8)) in_beat ();
  rcs_out_if #(.W(8)) out_beat ();

  rgb_contrast_stretch #(
    .COMPONENT_BITS(8)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .out_beat (out_beat)
  );

  rcs_stretch_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_beat),
    .out_mon    (out_beat),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_beat.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_beat.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_beat.valid && in_beat.ready) || (out_beat.valid && out_beat.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("rgb_contrast_stretch_tb failed");
    $finish;
  end

  task automatic send_pixel(logic op, logic start, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_beat.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    end
    in_beat.valid       <= 1'b1;
    in_beat.opcode      <= op;
    in_beat.start_frame <= start;
    in_beat.red_in      <= r;
    in_beat.green_in    <= g;
    in_beat.blue_in     <= b;
    @(posedge clk);
    while (!in_beat.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] probe_value(int lo, int hi);
    int v;
    case ($urandom_range(5))
      0:       v = lo;
      1:       v = hi;
      2:       v = lo - 1;
      3:       v = hi + 1;
      default: v = $urandom_range(255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic send_frame();
    int lo [3];
    int hi [3];
    int n_measure;
    int n_stretch;
    int kind;
    logic [7:0] px [3];
    kind = $urandom_range(9);
    if (kind == 0) begin
      repeat ($urandom_range(12, 1))
        send_pixel(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      return;
    end
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(3))
        0: begin
          lo[c] = $urandom_range(255);
          hi[c] = $urandom_range(255, lo[c]);
        end
        1: begin
          lo[c] = $urandom_range(248);
          hi[c] = lo[c] + $urandom_range(7);
        end
        2: begin
          lo[c] = $urandom_range(255);
          hi[c] = lo[c];
        end
        default: begin
          lo[c] = 0;
          hi[c] = 255;
        end
      endcase
    end
    n_measure = $urandom_range(12, 1);
    for (int i = 0; i < n_measure; i++) begin
      for (int c = 0; c < 3; c++) begin
        if (i == 0) px[c] = 8'(lo[c]);
        else if (i == 1) px[c] = 8'(hi[c]);
        else px[c] = 8'($urandom_range(hi[c], lo[c]));
      end
      send_pixel(OP_MEASURE, (i == 0) && (kind != 9), px[0], px[1], px[2]);
    end
    n_stretch = $urandom_range(12, 1);
    repeat (n_stretch) begin
      send_pixel(OP_STRETCH, 1'($urandom), probe_value(lo[0], hi[0]),
                 probe_value(lo[1], hi[1]), probe_value(lo[2], hi[2]));
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_beat.valid       = 1'b0;
    in_beat.opcode      = OP_MEASURE;
    in_beat.start_frame = 1'b0;
    in_beat.red_in      = 8'd0;
    in_beat.green_in    = 8'd0;
    in_beat.blue_in     = 8'd0;
    tx_idle_pct         = 13;
    rx_idle_pct         = 52;
    items_sent          = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no pixel measured yet
    send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd128, 8'd255);
    send_pixel(OP_STRETCH, 1'b1, 8'd255, 8'd0, 8'd1);
    // flat channels
    send_pixel(OP_MEASURE, 1'b1, 8'd100, 8'd100, 8'd100);
    send_pixel(OP_STRETCH, 1'b0, 8'd100, 8'd50, 8'd200);
    // widen without restart
    send_pixel(OP_MEASURE, 1'b0, 8'd50, 8'd0, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd75, 8'd0, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd49, 8'd100, 8'd99);
    send_pixel(OP_STRETCH, 1'b0, 8'd101, 8'd50, 8'd254);
    send_pixel(OP_STRETCH, 1'b0, 8'd255, 8'd255, 8'd0);
    send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd1, 8'd101);
    // full range
    send_pixel(OP_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd1, 8'd1, 8'd1);
    send_pixel(OP_STRETCH, 1'b0, 8'd254, 8'd254, 8'd254);
    send_pixel(OP_STRETCH, 1'b1, 8'd128, 8'd127, 8'd0);
    send_pixel(OP_STRETCH, 1'b0, 8'd255, 8'd0, 8'd170);
    // restart, flat at the top
    send_pixel(OP_MEASURE, 1'b1, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd255, 8'd0, 8'd254);
    // narrow span of one
    send_pixel(OP_MEASURE, 1'b1, 8'd10, 8'd200, 8'd0);
    send_pixel(OP_MEASURE, 1'b0, 8'd11, 8'd201, 8'd1);
    send_pixel(OP_STRETCH, 1'b0, 8'd10, 8'd201, 8'd0);
    send_pixel(OP_STRETCH, 1'b0, 8'd11, 8'd200, 8'd1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 52;
        end
        1: begin
          tx_idle_pct = 52;
          rx_idle_pct = 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (items_sent < PHASE_ITEMS * (phase + 1)) send_frame();
    end
    in_beat.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rgb_contrast_stretch_tb passed");
    end else begin
      $display("rgb_contrast_stretch_tb failed");
    end
    $finish;
  end

endmodule
